/* hdl/sor_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the ring generator.
// No dependencies.
package sor_pkg;

	localparam int DEF_PROFILE_MAX = 64;
	localparam int DEF_COORD_WIDTH = 16;
	localparam int STEP_W          = 12;
	localparam int IDX_W           = 18;
	localparam int PHASE_W         = 32;
	localparam int TRIG_W          = 33;
	localparam int ANG_W           = 20;
	localparam int CORDIC_ITERS    = 16;
	localparam int ITER_W          = 5;
	localparam int MUL_PHASES      = 5;

	localparam logic [STEP_W-1:0]        STEP_COUNT_RST = 12'd16;
	localparam logic [16:0]              ANG_SCALE      = 17'd102944;
	localparam logic signed [TRIG_W-1:0] X_INIT         = 33'sd652032874;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_EMIT   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic              accept;
		logic              div_step;
		logic              ang_load;
		logic              cord_step;
		logic              quad_load;
		logic              pt_first;
		logic              pt_next;
		logic              rd_en;
		logic              mul_en;
		logic              out_load;
		logic [ITER_W-1:0] iter;
	} dp_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic nonempty;
		logic is_last;
		logic out_free;
	} dp_stat_t;

	// atan(2^-k) in Q16 radians
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] k);
		logic signed [ANG_W-1:0] v;
		unique case (k)
			4'd0:  v = 20'sd51472;
			4'd1:  v = 20'sd30386;
			4'd2:  v = 20'sd16055;
			4'd3:  v = 20'sd8150;
			4'd4:  v = 20'sd4091;
			4'd5:  v = 20'sd2047;
			4'd6:  v = 20'sd1024;
			4'd7:  v = 20'sd512;
			4'd8:  v = 20'sd256;
			4'd9:  v = 20'sd128;
			4'd10: v = 20'sd64;
			4'd11: v = 20'sd32;
			4'd12: v = 20'sd16;
			4'd13: v = 20'sd8;
			4'd14: v = 20'sd4;
			default: v = 20'sd2;
		endcase
		return v;
	endfunction

endpackage

/* hdl/sor_ctrl.sv */
// Sequencer for the ring generator: steps the divider, CORDIC and per-point multiply.
// Depends on sor_pkg.
module sor_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         command,
	output logic               in_stall,
	input  sor_pkg::dp_stat_t  stat,
	output sor_pkg::dp_cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV  = 8'b0000_0010,
		S_ANG  = 8'b0000_0100,
		S_CORD = 8'b0000_1000,
		S_QUAD = 8'b0001_0000,
		S_READ = 8'b0010_0000,
		S_MUL  = 8'b0100_0000,
		S_PUT  = 8'b1000_0000
	} state_t;

	state_t                      state_q, state_d;
	logic [sor_pkg::ITER_W-1:0]  cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.iter = cnt_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (command == sor_pkg::CMD_EMIT && stat.emit_ok) begin
						state_d = S_DIV;
						cnt_d   = '0;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == sor_pkg::ITER_W'(sor_pkg::PHASE_W - 1)) begin
					state_d = S_ANG;
				end
			end
			S_ANG: begin
				cmd.ang_load = 1'b1;
				cnt_d   = '0;
				state_d = S_CORD;
			end
			S_CORD: begin
				cmd.cord_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == sor_pkg::ITER_W'(sor_pkg::CORDIC_ITERS - 1)) begin
					state_d = S_QUAD;
				end
			end
			S_QUAD: begin
				cmd.quad_load = 1'b1;
				cmd.pt_first  = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				cnt_d   = '0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == sor_pkg::ITER_W'(sor_pkg::MUL_PHASES - 1)) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (stat.is_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.pt_next = 1'b1;
						state_d = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* hdl/sor_dp.sv */
// Datapath: profile memory, phase divider, CORDIC, shared multiplier, output register.
// Depends on sor_pkg; driven by sor_ctrl.
module sor_dp #(
	parameter int PROFILE_MAX = sor_pkg::DEF_PROFILE_MAX,
	parameter int COORD_WIDTH = sor_pkg::DEF_COORD_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sor_pkg::STEP_W-1:0]        cfg_wdata,
	input  logic [1:0]                        command,
	input  logic signed [COORD_WIDTH-1:0]     point_x,
	input  logic signed [COORD_WIDTH-1:0]     point_y,
	input  logic signed [COORD_WIDTH-1:0]     normal_x,
	input  logic signed [COORD_WIDTH-1:0]     normal_y,
	input  logic [sor_pkg::STEP_W-1:0]        step_index,
	input  sor_pkg::dp_cmd_t                  cmd,
	output sor_pkg::dp_stat_t                 stat,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [COORD_WIDTH-1:0]     vertex_x,
	output logic signed [COORD_WIDTH-1:0]     vertex_y,
	output logic signed [COORD_WIDTH-1:0]     vertex_z,
	output logic signed [COORD_WIDTH-1:0]     out_normal_x,
	output logic signed [COORD_WIDTH-1:0]     out_normal_y,
	output logic signed [COORD_WIDTH-1:0]     out_normal_z,
	output logic [sor_pkg::IDX_W-1:0]         vertex_index,
	output logic                              last_of_ring
);

	localparam int AW   = (PROFILE_MAX > 1) ? $clog2(PROFILE_MAX) : 1;
	localparam int CNTW = $clog2(PROFILE_MAX + 1);
	localparam int CW   = COORD_WIDTH;
	localparam int TW   = sor_pkg::TRIG_W;
	localparam int PW   = CW + TW;
	localparam int SW   = sor_pkg::STEP_W;
	localparam int BW   = SW + CNTW;

	localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< 29);
	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
	localparam logic signed [CW-1:0] CMAX = CW'(SMAX);
	localparam logic signed [CW-1:0] CMIN = CW'(SMIN);

	logic [SW-1:0]          step_count_q;
	logic [CNTW-1:0]        count_q;
	logic [4*CW-1:0]        mem [PROFILE_MAX];
	logic [4*CW-1:0]        rd_q;
	logic [sor_pkg::IDX_W-1:0] base_q;
	logic [SW-1:0]          rem_q;
	logic [sor_pkg::PHASE_W-1:0] quo_q;
	logic signed [TW-1:0]   cx_q, cy_q, c_q, s_q;
	logic signed [sor_pkg::ANG_W-1:0] cz_q;
	logic [AW-1:0]          j_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [CW-1:0]   vx_q, vz_q, onx_q, onz_q;

	// ring setup
	logic [BW-1:0]          base_full;
	logic [SW:0]            rem_sh;
	logic                   rem_ge;
	logic [46:0]            ang_prod;
	logic signed [TW-1:0]   dx, dy, c_w, s_w;
	logic [3:0]             k;
	logic                   emit_acc;

	assign emit_acc  = cmd.accept && command == sor_pkg::CMD_EMIT && stat.emit_ok;
	assign base_full = step_index * count_q;
	assign rem_sh    = {rem_q, 1'b0};
	assign rem_ge    = rem_sh >= {1'b0, step_count_q};
	assign ang_prod  = quo_q[29:0] * sor_pkg::ANG_SCALE;
	assign k         = cmd.iter[3:0];
	assign dx        = cy_q >>> k;
	assign dy        = cx_q >>> k;

	always_comb begin
		case (quo_q[31:30])
			2'd0:    begin c_w = cx_q;  s_w = cy_q;  end
			2'd1:    begin c_w = -cy_q; s_w = cx_q;  end
			2'd2:    begin c_w = -cx_q; s_w = -cy_q; end
			default: begin c_w = cy_q;  s_w = -cx_q; end
		endcase
	end

	// per point
	logic signed [CW-1:0] px, py, nx, ny, mul_a, ny_neg, sat_v;
	logic signed [TW-1:0] mul_b;
	logic signed [PW-1:0] prod_w, rnd;

	assign px = rd_q[4*CW-1:3*CW];
	assign py = rd_q[3*CW-1:2*CW];
	assign nx = rd_q[2*CW-1:CW];
	assign ny = rd_q[CW-1:0];

	always_comb begin
		case (cmd.iter[1:0])
			2'd0:    begin mul_a = px; mul_b = c_q;  end
			2'd1:    begin mul_a = px; mul_b = -s_q; end
			2'd2:    begin mul_a = nx; mul_b = -c_q; end
			default: begin mul_a = nx; mul_b = s_q;  end
		endcase
	end

	assign prod_w = mul_a * mul_b;
	assign rnd    = (prod_q + HALF) >>> 30;
	assign sat_v  = (rnd > SMAX) ? CMAX : ((rnd < SMIN) ? CMIN : CW'(rnd));
	assign ny_neg = (ny == CMIN) ? CMAX : -ny;

	assign stat.emit_ok  = step_count_q != '0 && step_index < step_count_q && count_q != '0;
	assign stat.nonempty = count_q != '0;
	assign stat.is_last  = (CNTW'(j_q) + CNTW'(1)) == count_q;
	assign stat.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= sor_pkg::STEP_COUNT_RST;
			count_q      <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_count_q <= cfg_wdata;
			end
			if (cmd.accept && command == sor_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else if (cmd.accept && command == sor_pkg::CMD_APPEND &&
				count_q != CNTW'(PROFILE_MAX)) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && command == sor_pkg::CMD_APPEND && count_q != CNTW'(PROFILE_MAX)) begin
			mem[count_q[AW-1:0]] <= {point_x, point_y, normal_x, normal_y};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_acc) begin
			base_q <= sor_pkg::IDX_W'(base_full);
			rem_q  <= step_index;
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? SW'(rem_sh - {1'b0, step_count_q}) : rem_sh[SW-1:0];
			quo_q <= {quo_q[sor_pkg::PHASE_W-2:0], rem_ge};
		end
		if (cmd.ang_load) begin
			cx_q <= sor_pkg::X_INIT;
			cy_q <= '0;
			cz_q <= signed'(sor_pkg::ANG_W'(ang_prod[46:30]));
		end
		if (cmd.cord_step) begin
			if (!cz_q[sor_pkg::ANG_W-1]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - sor_pkg::atan_q16(k);
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + sor_pkg::atan_q16(k);
			end
		end
		if (cmd.quad_load) begin
			c_q <= c_w;
			s_q <= s_w;
		end
		if (cmd.pt_first) begin
			j_q <= '0;
		end else if (cmd.pt_next) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_w;
			case (cmd.iter)
				sor_pkg::ITER_W'(1): vx_q  <= sat_v;
				sor_pkg::ITER_W'(2): vz_q  <= sat_v;
				sor_pkg::ITER_W'(3): onx_q <= sat_v;
				sor_pkg::ITER_W'(4): onz_q <= sat_v;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			vertex_x     <= vx_q;
			vertex_y     <= py;
			vertex_z     <= vz_q;
			out_normal_x <= onx_q;
			out_normal_y <= ny_neg;
			out_normal_z <= onz_q;
			vertex_index <= base_q + sor_pkg::IDX_W'(j_q);
			last_of_ring <= stat.is_last;
		end
	end

endmodule

/* hdl/surface_of_revolution_ring_gen.sv */
// Ring generator: clear and append are taken while idle; emit of an n-point ring
// runs the phase divide and CORDIC, then per point a read, the multiply phases on
// the single multiplier and an output load that offers the point's beat.
// One item in work at a time; the output register lets the next item enter while
// the last beat waits. arst_n clears the profile count, step_count to 16, and the
// sequencer; stored profile entries are not cleared.
module surface_of_revolution_ring_gen #(
	parameter int PROFILE_MAX = sor_pkg::DEF_PROFILE_MAX,
	parameter int COORD_WIDTH = sor_pkg::DEF_COORD_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config: step_count
	input  logic                              cfg_we,
	input  logic [sor_pkg::STEP_W-1:0]        cfg_wdata,
	// input beat
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic signed [COORD_WIDTH-1:0]     point_x,
	input  logic signed [COORD_WIDTH-1:0]     point_y,
	input  logic signed [COORD_WIDTH-1:0]     normal_x,
	input  logic signed [COORD_WIDTH-1:0]     normal_y,
	input  logic [sor_pkg::STEP_W-1:0]        step_index,
	// output beat, one per stored point
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [COORD_WIDTH-1:0]     vertex_x,
	output logic signed [COORD_WIDTH-1:0]     vertex_y,
	output logic signed [COORD_WIDTH-1:0]     vertex_z,
	output logic signed [COORD_WIDTH-1:0]     out_normal_x,
	output logic signed [COORD_WIDTH-1:0]     out_normal_y,
	output logic signed [COORD_WIDTH-1:0]     out_normal_z,
	output logic [sor_pkg::IDX_W-1:0]         vertex_index,
	output logic                              last_of_ring
);

	sor_pkg::dp_cmd_t  cmd;
	sor_pkg::dp_stat_t stat;

	// sequencer: owns the input handshake
	sor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: profile store, divider, CORDIC, multiplier, output register
	sor_dp #(
		.PROFILE_MAX (PROFILE_MAX),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.command      (command),
		.point_x      (point_x),
		.point_y      (point_y),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.step_index   (step_index),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.out_normal_x (out_normal_x),
		.out_normal_y (out_normal_y),
		.out_normal_z (out_normal_z),
		.vertex_index (vertex_index),
		.last_of_ring (last_of_ring)
	);

	// an accepted ring emit closes the input until the ring is done
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == sor_pkg::CMD_EMIT && stat.emit_ok) |=> in_stall)
		else $error("input open right after ring emit accepted");

	// a clear empties the profile
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == sor_pkg::CMD_CLEAR) |=> !stat.nonempty)
		else $error("profile not empty after clear");

	// output register is loaded only when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output beat overwritten");

endmodule

/* test/ring_checker.sv */
// Checker for the ring generator: watches config, input and output beats,
// predicts each ring with its own CORDIC and compares every output beat.
// Depends on sor_pkg for the command codes and field widths.
module ring_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sor_pkg::STEP_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic signed [15:0]            point_x,
	input  logic signed [15:0]            point_y,
	input  logic signed [15:0]            normal_x,
	input  logic signed [15:0]            normal_y,
	input  logic [sor_pkg::STEP_W-1:0]    step_index,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [15:0]            vertex_x,
	input  logic signed [15:0]            vertex_y,
	input  logic signed [15:0]            vertex_z,
	input  logic signed [15:0]            out_normal_x,
	input  logic signed [15:0]            out_normal_y,
	input  logic signed [15:0]            out_normal_z,
	input  logic [sor_pkg::IDX_W-1:0]     vertex_index,
	input  logic                          last_of_ring,
	output int                            fail_count,
	output int                            pending,
	output int                            beats_seen
);

	localparam int PTS = 64;

	typedef struct {
		logic signed [15:0]          vx, vy, vz, nx, ny, nz;
		logic [sor_pkg::IDX_W-1:0]   idx;
		logic                        last;
	} ring_beat_t;

	typedef struct {
		logic signed [15:0] px, py, nx, ny;
	} prof_pt_t;

	localparam longint ARCTAN[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	prof_pt_t                   prof[PTS];
	int                         prof_len;
	logic [sor_pkg::STEP_W-1:0] n_steps;
	ring_beat_t                 ring_q[$];

	assign pending = ring_q.size();

	function automatic longint clamp16(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint scale(input longint v, input longint t);
		return clamp16((v * t + (64'sd1 <<< 29)) >>> 30);
	endfunction

	// phase in 2^-32 turns -> (cos, sin) in Q30
	task automatic trig_of(input logic [31:0] phase, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = (longint'(phase[29:0]) * 102944) >>> 30;
		for (int k = 0; k < 16; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[k];
			end else begin
				x += dx; y -= dy; z += ARCTAN[k];
			end
		end
		case (phase[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_ring(input logic [sor_pkg::STEP_W-1:0] si);
		longint c, s;
		logic [63:0] ph;
		ring_beat_t b;
		if (n_steps == 0 || si >= n_steps || prof_len == 0)
			return;
		ph = ({52'd0, si} << 32) / n_steps;
		trig_of(ph[31:0], c, s);
		for (int j = 0; j < prof_len; j++) begin
			b.vx   = 16'(scale(prof[j].px, c));
			b.vy   = prof[j].py;
			b.vz   = 16'(scale(prof[j].px, -s));
			b.nx   = 16'(scale(prof[j].nx, -c));
			b.ny   = 16'(clamp16(-longint'(prof[j].ny)));
			b.nz   = 16'(scale(prof[j].nx, s));
			b.idx  = sor_pkg::IDX_W'(longint'(si) * prof_len + j);
			b.last = (j + 1 == prof_len);
			ring_q.insert(ring_q.size(), b);
		end
	endtask

	function automatic void check_field(input string name, input longint exp, input longint act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_beat_t e;
		if (!arst_n) begin
			prof_len   = 0;
			n_steps    = sor_pkg::STEP_COUNT_RST;
			fail_count = 0;
			beats_seen = 0;
			ring_q.delete();
		end else begin
			if (cfg_we)
				n_steps = cfg_wdata;
			if (in_valid && !in_stall) begin
				case (command)
					sor_pkg::CMD_CLEAR: prof_len = 0;
					sor_pkg::CMD_APPEND: if (prof_len < PTS) begin
						prof[prof_len] = '{point_x, point_y, normal_x, normal_y};
						prof_len++;
					end
					sor_pkg::CMD_EMIT: predict_ring(step_index);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (ring_q.size() == 0) begin
					$error("output beat with nothing expected (index %0d)", vertex_index);
					fail_count++;
				end else begin
					e = ring_q.pop_front();
					check_field("vertex_x", e.vx, vertex_x);
					check_field("vertex_y", e.vy, vertex_y);
					check_field("vertex_z", e.vz, vertex_z);
					check_field("out_normal_x", e.nx, out_normal_x);
					check_field("out_normal_y", e.ny, out_normal_y);
					check_field("out_normal_z", e.nz, out_normal_z);
					check_field("vertex_index", e.idx, vertex_index);
					check_field("last_of_ring", e.last, last_of_ring);
				end
			end
		end
	end

endmodule

/* test/tb_top.sv */
// Top of the ring generator testbench: clock, reset, stimulus, receiver stalls
// and verdict. Prediction and comparison live in ring_checker; needs sor_pkg.
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              cfg_we = 1'b0;
	logic [sor_pkg::STEP_W-1:0]        cfg_wdata = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        command = sor_pkg::CMD_CLEAR;
	logic signed [15:0]       point_x = '0, point_y = '0, normal_x = '0, normal_y = '0;
	logic [sor_pkg::STEP_W-1:0]        step_index = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [15:0]                vertex_x, vertex_y, vertex_z;
	logic signed [15:0]                out_normal_x, out_normal_y, out_normal_z;
	logic [sor_pkg::IDX_W-1:0]         vertex_index;
	logic                              last_of_ring;

	int fail_count, pending, beats_seen;
	int items_sent = 0;
	int stall_cycles = 0;
	bit quiet = 0;           // no idling on either side while set
	bit hold_req = 0;        // asks the receiver for one long hold-off
	int hold_len = 0;
	logic [sor_pkg::STEP_W-1:0] cur_steps = sor_pkg::STEP_COUNT_RST;

	localparam int WATCHDOG_LIMIT = 20000;

	always #4 clk = ~clk;

	surface_of_revolution_ring_gen dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.point_x(point_x), .point_y(point_y), .normal_x(normal_x), .normal_y(normal_y),
		.step_index(step_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
		.out_normal_z(out_normal_z),
		.vertex_index(vertex_index), .last_of_ring(last_of_ring)
	);

	ring_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.point_x(point_x), .point_y(point_y), .normal_x(normal_x), .normal_y(normal_y),
		.step_index(step_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
		.out_normal_z(out_normal_z),
		.vertex_index(vertex_index), .last_of_ring(last_of_ring),
		.fail_count(fail_count), .pending(pending), .beats_seen(beats_seen)
	);

	// Receiver: random stalls, or one long hold-off when asked. The hold-off is
	// counted here so the sender keeps pushing beats into the block meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				hold_len--;
			end else if (hold_req) begin
				hold_req = 0;
				hold_len = 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < 33);
			end
		end
	end

	// Watchdog: cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Called at a rising edge; the beat is offered from this edge on. The task returns
	// at the edge that accepted it with valid still high, unless it then idles (valid low).
	task automatic offer(input logic [1:0] cmd, input logic signed [15:0] px, py, nx, ny,
			input logic [sor_pkg::STEP_W-1:0] si);
		command    <= cmd;
		point_x    <= px;
		point_y    <= py;
		normal_x   <= nx;
		normal_y   <= ny;
		step_index <= si;
		in_valid   <= 1'b1;
		// stall is settled mid-cycle, so sample it on the falling edge
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		items_sent++;
		if (!quiet && $urandom_range(0, 99) < 33)
			idle_for($urandom_range(1, 4));
	endtask

	task automatic idle_for(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender pause: hold until every expected beat is out, plus the emit latency
	// so that a ring with no beats has surely finished too.
	task automatic drain();
		idle_for(1);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_steps(input logic [sor_pkg::STEP_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_steps = v;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] any_coord();
		case ($urandom_range(0, 7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return '0;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [sor_pkg::STEP_W-1:0] any_step();
		if ($urandom_range(0, 9) < 8)
			return sor_pkg::STEP_W'($urandom_range(0, cur_steps - 1));
		return sor_pkg::STEP_W'($urandom_range(0, 4095));
	endfunction

	task automatic add_point();
		offer(sor_pkg::CMD_APPEND, any_coord(), any_coord(), any_coord(), any_coord(), '0);
	endtask

	task automatic emit(input logic [sor_pkg::STEP_W-1:0] si);
		offer(sor_pkg::CMD_EMIT, any_coord(), any_coord(), any_coord(), any_coord(), si);
	endtask

	// Mostly short profiles built up and swept by rings; some junk commands.
	task automatic random_run(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				offer(sor_pkg::CMD_NONE, any_coord(), any_coord(), any_coord(), any_coord(),
					sor_pkg::STEP_W'($urandom()));
			else if (r < 14)
				offer(sor_pkg::CMD_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
					sor_pkg::STEP_W'($urandom()));
			else if (r < 52)
				add_point();
			else
				emit(any_step());
		end
	endtask

	initial begin
		logic [sor_pkg::STEP_W-1:0] mid_steps;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty profile, junk command, extreme coordinates, ring steps
		// around the default turn, a step past the end, and the largest step.
		set_steps(sor_pkg::STEP_COUNT_RST);
		offer(sor_pkg::CMD_EMIT, '0, '0, '0, '0, 12'd0);
		offer(sor_pkg::CMD_NONE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 12'hfff);
		offer(sor_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
		offer(sor_pkg::CMD_APPEND, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, '0);
		offer(sor_pkg::CMD_APPEND, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, '0);
		offer(sor_pkg::CMD_APPEND, '0, '0, '0, '0, '0);
		offer(sor_pkg::CMD_APPEND, -16'sd1, 16'sd1, 16'sd4096, -16'sd4096, '0);
		for (int st = 0; st < 16; st += 4)
			emit(sor_pkg::STEP_W'(st));
		emit(12'd15);
		emit(12'd16);
		emit(12'hfff);
		offer(sor_pkg::CMD_NONE, '0, '0, '0, '0, 12'd3);
		emit(12'd3);
		offer(sor_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
		emit(12'd1);

		// Fill the store past its end: the extra appends are dropped.
		offer(sor_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);
		repeat (66) add_point();
		emit(12'd5);
		emit(12'd11);
		offer(sor_pkg::CMD_CLEAR, '0, '0, '0, '0, '0);

		set_steps(12'd1);
		random_run(60);

		// No idling at all in this phase.
		set_steps(12'd4095);
		quiet = 1;
		random_run(60);
		quiet = 0;

		// Long receiver hold-off while rings keep coming in.
		set_steps(12'd3);
		repeat (3) add_point();
		hold_req = 1;
		repeat (6) emit(any_step());
		random_run(50);

		mid_steps = sor_pkg::STEP_W'($urandom_range(1, 4095));
		set_steps(mid_steps);
		random_run(60);

		set_steps(12'd7);
		random_run(60);

		set_steps(12'd2048);
		random_run(60);

		set_steps(12'd16);
		random_run(40);

		drain();
		$display("run covered %0d input beats and %0d output beats over 8 step counts",
			items_sent, beats_seen);
		$display("including full store, out-of-range steps, empty rings and a long hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
